// File: src/lqrbc_pkg.sv
// Shared types and constants of the LQR balance controller.
// No dependencies; every other file but lqrbc_sine_rom refers to this package by scoped names.
`default_nettype none
package lqrbc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GAIN_FRAC = 20;
  localparam int SIN_FRAC  = 30;
  localparam int STATE_DIM = 6;

  // Q.32 turns per radian, and the leg model terms in Q.20
  localparam logic signed [31:0] INV_2PI_Q32 = 32'sd683565276;
  localparam logic signed [31:0] GH_Q20      = 32'sd11691085;
  localparam logic signed [31:0] MG_Q20      = 32'sd91302658;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Divider magnitudes: numerator below 2^54, denominator below 2^28
  localparam int DVD_W = 54;
  localparam int DVS_W = 28;

  localparam logic signed [31:0] WHEEL_GAIN [2][STATE_DIM] = '{
    '{-32'sd14412760, -32'sd52382850, -32'sd485414919,
      -32'sd34577579, -32'sd53955489, -32'sd117771125},
    '{-32'sd14709276, -32'sd43826081, -32'sd484083805,
      -32'sd34241961, -32'sd48829054, -32'sd117884283}
  };
  localparam logic signed [31:0] LEG_GAIN [2][STATE_DIM] = '{
    '{-32'sd203923, 32'sd1885449, -32'sd5770736,
      -32'sd507751, 32'sd2112665, -32'sd4073538},
    '{-32'sd193184, 32'sd1697238, -32'sd5299325,
      -32'sd462112, 32'sd1999471, -32'sd3846063}
  };

  typedef enum logic [2:0] {
    CFG_VEL_STEP    = 3'd0,
    CFG_PITCH_STEP  = 3'd1,
    CFG_GAIN_SWITCH = 3'd2,
    CFG_WHEEL_RAD   = 3'd3,
    CFG_TICK_PERIOD = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] body_pos;
    logic signed [31:0] leg_pos;
    logic signed [31:0] leg_vel;
    logic signed [31:0] body_pitch;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] left_wheel_speed;
    logic signed [31:0] right_wheel_speed;
    logic signed [31:0] speed_cmd;
    logic signed [31:0] yaw_cmd;
    logic signed [31:0] pitch_cmd;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] left_torque;
    logic signed [31:0] right_torque;
    logic signed [31:0] leg_force;
    logic signed [31:0] leg_reference;
    logic               second_gains;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: src/lqrbc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on lqrbc_pkg for operand widths.
`default_nettype none
module lqrbc_mul (
  input  wire logic                                  clk,
  input  wire logic signed [lqrbc_pkg::MUL_A_W-1:0] a,
  input  wire logic signed [lqrbc_pkg::MUL_B_W-1:0] b,
  output logic signed [lqrbc_pkg::MUL_P_W-1:0]      prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= lqrbc_pkg::MUL_P_W'(a) * lqrbc_pkg::MUL_P_W'(b);
  end

endmodule
`default_nettype wire

// File: src/lqrbc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lqrbc_pkg for the request and response structs.
`default_nettype none
module lqrbc_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lqrbc_pkg::div_req_t req,
  output lqrbc_pkg::div_rsp_t      rsp
);

  localparam int DVD_W = lqrbc_pkg::DVD_W;
  localparam int DVS_W = lqrbc_pkg::DVS_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   rem_r;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_n;
  logic             ge;

  always_comb begin
    rem_sh = {rem_r[DVS_W-1:0], dvd_r[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs_r};
    rem_n  = ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_n;
        dvd_r <= {dvd_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule
`default_nettype wire

// File: src/lqrbc_sine_rom.sv
// Full-turn Q.30 sine table with a registered read port.
// Entries come from a Taylor series worked out at elaboration; uses no package.
`default_nettype none
module lqrbc_sine_rom #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  output logic signed [31:0]            data_r
);

  localparam int     AW          = $clog2(DEPTH);
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;

  typedef logic signed [31:0] rom_t [DEPTH];

  // Shift-and-subtract quotient, truncated toward zero
  function automatic longint div_trunc(input longint n, input longint d);
    logic [63:0] un;
    logic [63:0] ud;
    logic [63:0] q;
    logic [63:0] r;
    logic        neg;
    neg = (n < 0) != (d < 0);
    un  = (n < 0) ? 64'(-n) : 64'(n);
    ud  = (d < 0) ? 64'(-d) : 64'(d);
    q   = '0;
    r   = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], un[i]};
      if (r >= ud) begin
        r    = r - ud;
        q[i] = 1'b1;
      end
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] sine_entry(input int k);
    longint x;
    longint x2;
    longint term;
    longint sum;
    logic   neg;
    x   = (TWO_PI_Q30 * longint'(k)) >>> AW;
    neg = 1'b0;
    if (x > PI_Q30) begin
      x   = x - PI_Q30;
      neg = 1'b1;
    end
    if (x > HALF_PI_Q30) x = PI_Q30 - x;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 9; n++) begin
      term = div_trunc(-((term * x2) >>> 30), longint'((2 * n) * (2 * n + 1)));
      sum  = sum + term;
    end
    if (sum > ONE_Q30) sum = ONE_Q30;
    if (sum < 0) sum = 0;
    if (neg) sum = -sum;
    return sum[31:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < DEPTH; k++) r[k] = sine_entry(k);
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  always_ff @(posedge clk) begin
    data_r <= SINE_ROM[addr];
  end

endmodule
`default_nettype wire

// File: src/lqr_balance_controller_core.sv
// Top level of the LQR balance controller: sequencer, state and datapath.
// Depends on lqrbc_pkg, lqrbc_mul, lqrbc_div and lqrbc_sine_rom.
//
// One item is one control tick. A single registered 33x32 multiplier is
// shared by every product of the tick under a one-hot sequencer: wheel speed,
// position integration, the twelve gain products of the two dot products,
// the wheel torque, and, when the limited speed is zero, the angle-to-turn
// conversion, two sine interpolations and the two leg model products. At rest
// the leg reference also needs a restoring divide of 54 quotient bits, unless
// the cosine term is zero. in_ready is high only while idle; a finished item
// waits in the output register and the block takes the next item while it
// waits. Configuration writes are always ready and take effect at once.
`default_nettype none
module lqr_balance_controller_core #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lqrbc_pkg::in_item_t  in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output lqrbc_pkg::out_item_t      out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [16:0]          cfg_data
);

  localparam int ROM_AW = $clog2(SINE_TABLE_DEPTH);
  localparam int FB     = lqrbc_pkg::FRAC_BITS;
  localparam int DVD_W  = lqrbc_pkg::DVD_W;
  localparam int DVS_W  = lqrbc_pkg::DVS_W;

  typedef enum logic [24:0] {
    ST_IDLE     = 25'h0000001,
    ST_SLEW     = 25'h0000002,
    ST_M_SPEED  = 25'h0000004,
    ST_M_POS    = 25'h0000008,
    ST_POS      = 25'h0000010,
    ST_DOT      = 25'h0000020,
    ST_DOT_END  = 25'h0000040,
    ST_WSAT     = 25'h0000080,
    ST_M_TAU    = 25'h0000100,
    ST_TAU      = 25'h0000200,
    ST_LR       = 25'h0000400,
    ST_M_TURN   = 25'h0000800,
    ST_TURN     = 25'h0001000,
    ST_SA       = 25'h0002000,
    ST_SB       = 25'h0004000,
    ST_CA       = 25'h0008000,
    ST_CB       = 25'h0010000,
    ST_M_C      = 25'h0020000,
    ST_CMUL     = 25'h0040000,
    ST_GH       = 25'h0080000,
    ST_MG       = 25'h0100000,
    ST_NUM      = 25'h0200000,
    ST_DIV      = 25'h0400000,
    ST_DIV_WAIT = 25'h0800000,
    ST_FINISH   = 25'h1000000
  } state_t;

  // Round half up at bit s, then floor
  function automatic logic signed [65:0] rnd(input logic signed [65:0] x, input int s);
    return (x + (66'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    else if (x < -66'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

  // Step towards the command by at most step, snap when the gap is smaller
  function automatic logic signed [31:0] slew(input logic signed [31:0] cur,
                                              input logic signed [31:0] cmd,
                                              input logic [16:0] step);
    logic signed [33:0] d;
    logic signed [33:0] st;
    d  = 34'(cmd) - 34'(cur);
    st = $signed({17'b0, step});
    if (d >= st) return cur + {15'b0, step};
    else if (d <= -st) return cur - {15'b0, step};
    else return cmd;
  endfunction

  // Configuration
  logic [16:0] vel_step_r, pitch_step_r, wheel_rad_r, tick_per_r;
  logic [15:0] gain_tick_r;

  // Controller state carried between ticks
  state_t             state_r;
  logic signed [31:0] ls_r, lp_r, posref_r;
  logic signed [31:0] rv_pos_r, rv_leg_r, rv_pitch_r, rv_speed_r;
  logic [15:0]        tick_r;
  logic               gain_r;
  logic               gain_nxt;

  // Per-item working registers
  lqrbc_pkg::in_item_t  in_r;
  lqrbc_pkg::out_item_t out_r;
  logic                 out_valid_r;
  logic                 commit;
  logic signed [32:0]   whl_sum_r, diff_r, lrsum_r;
  logic signed [31:0]   speed_r, wsum_r, force_r, tau_r, left_r, right_r;
  logic signed [31:0]   sa_r, ca_r, s_r, c_r, leg_ref_r;
  logic signed [63:0]   wacc_r, lacc_r;
  logic [3:0]           dot_r;
  logic                 pend_r, pend_leg_r;
  logic [31:0]          t_r;
  logic signed [65:0]   ghs_r;
  logic signed [DVD_W:0] num_r;
  logic signed [DVS_W:0] den_r;

  // Shared multiplier
  logic signed [lqrbc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [lqrbc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [lqrbc_pkg::MUL_P_W-1:0] prod_r;
  logic signed [65:0]                   prod;

  // Sine table
  logic [ROM_AW-1:0]  rom_addr;
  logic signed [31:0] rom_q;
  logic [31:0]        t_cos;
  logic [ROM_AW-1:0]  idx_s, idx_c;
  logic [15:0]        frac_s, frac_c;

  // Divider
  lqrbc_pkg::div_req_t div_req;
  lqrbc_pkg::div_rsp_t div_rsp;
  logic                neg_q;
  logic signed [65:0]  q_signed;

  // Dot product element select
  logic [2:0]         elt;
  logic signed [31:0] x_sel, r_sel, e_sel;

  lqrbc_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  lqrbc_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (rom_q)
  );

  lqrbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign prod = 66'(prod_r);

  // Turn fraction to table index and interpolation fraction
  assign t_cos  = t_r + 32'h4000_0000;
  assign idx_s  = t_r[31 -: ROM_AW];
  assign idx_c  = t_cos[31 -: ROM_AW];
  assign frac_s = t_r[31 - ROM_AW -: 16];
  assign frac_c = t_cos[31 - ROM_AW -: 16];

  // Error vector element: [pos, leg, pitch, speed, leg_vel, pitch_rate]
  assign elt = dot_r[3:1];
  always_comb begin
    case (elt)
      3'd0: begin
        x_sel = in_r.body_pos;
        r_sel = rv_pos_r;
      end
      3'd1: begin
        x_sel = in_r.leg_pos;
        r_sel = rv_leg_r;
      end
      3'd2: begin
        x_sel = in_r.body_pitch;
        r_sel = rv_pitch_r;
      end
      3'd3: begin
        x_sel = speed_r;
        r_sel = rv_speed_r;
      end
      3'd4: begin
        x_sel = in_r.leg_vel;
        r_sel = '0;
      end
      default: begin
        x_sel = in_r.pitch_rate;
        r_sel = '0;
      end
    endcase
    e_sel = sat32(66'(x_sel) - 66'(r_sel));
  end

  // Multiplier operand select: each state below issues one product
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_M_SPEED: begin
        mul_a = whl_sum_r;
        mul_b = {15'b0, wheel_rad_r};
      end
      ST_M_POS: begin
        mul_a = 33'(ls_r);
        mul_b = {15'b0, tick_per_r};
      end
      ST_DOT: begin
        mul_a = 33'(e_sel);
        mul_b = dot_r[0] ? lqrbc_pkg::LEG_GAIN[gain_r][elt]
                         : lqrbc_pkg::WHEEL_GAIN[gain_r][elt];
      end
      ST_M_TAU: begin
        mul_a = 33'(wsum_r);
        mul_b = {15'b0, wheel_rad_r};
      end
      ST_M_TURN: begin
        mul_a = 33'(lp_r);
        mul_b = lqrbc_pkg::INV_2PI_Q32;
      end
      ST_CB: begin
        mul_a = diff_r;
        mul_b = {16'b0, frac_s};
      end
      ST_CMUL: begin
        mul_a = diff_r;
        mul_b = {16'b0, frac_c};
      end
      ST_GH: begin
        mul_a = 33'(s_r);
        mul_b = lqrbc_pkg::GH_Q20;
      end
      ST_MG: begin
        mul_a = 33'(c_r);
        mul_b = lqrbc_pkg::MG_Q20;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Table address: sine pair, then cosine pair
  always_comb begin
    case (state_r)
      ST_SA:   rom_addr = idx_s;
      ST_SB:   rom_addr = idx_s + 1'b1;
      ST_CA:   rom_addr = idx_c;
      ST_CB:   rom_addr = idx_c + 1'b1;
      default: rom_addr = idx_s;
    endcase
  end

  // Divider launch on magnitudes, sign applied afterwards
  always_comb begin
    logic signed [DVD_W:0] num_mag;
    logic signed [DVS_W:0] den_mag;
    num_mag          = num_r[DVD_W] ? -num_r : num_r;
    den_mag          = den_r[DVS_W] ? -den_r : den_r;
    div_req.start    = (state_r == ST_DIV) && (den_r != '0);
    div_req.dividend = num_mag[DVD_W-1:0];
    div_req.divisor  = den_mag[DVS_W-1:0];
  end

  assign neg_q    = num_r[DVD_W] ^ den_r[DVS_W];
  assign q_signed = neg_q ? -$signed(66'(div_rsp.quotient)) : $signed(66'(div_rsp.quotient));

  assign gain_nxt = gain_r | (tick_r == gain_tick_r);

  // Commit the tick once the output register is free
  assign commit = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  // Raise on commit, drop once the waiting item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      vel_step_r   <= 17'd92;
      pitch_step_r <= 17'd13;
      gain_tick_r  <= 16'd1500;
      wheel_rad_r  <= 17'd4260;
      tick_per_r   <= 17'd131;
      ls_r         <= '0;
      lp_r         <= '0;
      posref_r     <= '0;
      rv_pos_r     <= '0;
      rv_leg_r     <= '0;
      rv_pitch_r   <= '0;
      rv_speed_r   <= '0;
      tick_r       <= '0;
      gain_r       <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      // Register writes; unknown indexes are dropped
      if (cfg_valid) begin
        case (cfg_index)
          lqrbc_pkg::CFG_VEL_STEP:    vel_step_r   <= cfg_data;
          lqrbc_pkg::CFG_PITCH_STEP:  pitch_step_r <= cfg_data;
          lqrbc_pkg::CFG_GAIN_SWITCH: gain_tick_r  <= cfg_data[15:0];
          lqrbc_pkg::CFG_WHEEL_RAD:   wheel_rad_r  <= cfg_data;
          lqrbc_pkg::CFG_TICK_PERIOD: tick_per_r   <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            in_r    <= in_item;
            state_r <= ST_SLEW;
          end
        end
        ST_SLEW: begin
          ls_r      <= slew(ls_r, in_r.speed_cmd, vel_step_r);
          lp_r      <= slew(lp_r, in_r.pitch_cmd, pitch_step_r);
          whl_sum_r <= 33'(in_r.left_wheel_speed) + 33'(in_r.right_wheel_speed);
          wacc_r    <= '0;
          lacc_r    <= '0;
          dot_r     <= '0;
          pend_r    <= 1'b0;
          state_r   <= ST_M_SPEED;
        end
        ST_M_SPEED: state_r <= ST_M_POS;
        ST_M_POS: begin
          speed_r <= sat32(rnd(prod, FB + 1));
          state_r <= ST_POS;
        end
        ST_POS: begin
          posref_r <= sat32(66'(posref_r) + rnd(prod, FB));
          state_r  <= ST_DOT;
        end
        ST_DOT: begin
          // Accumulate last cycle's product while issuing the next
          if (pend_r) begin
            if (pend_leg_r) lacc_r <= lacc_r + $signed(prod_r[63:0]);
            else            wacc_r <= wacc_r + $signed(prod_r[63:0]);
          end
          pend_r     <= 1'b1;
          pend_leg_r <= dot_r[0];
          dot_r      <= dot_r + 1'b1;
          if (dot_r == 4'(2 * lqrbc_pkg::STATE_DIM - 1)) state_r <= ST_DOT_END;
        end
        ST_DOT_END: begin
          if (pend_leg_r) lacc_r <= lacc_r + $signed(prod_r[63:0]);
          else            wacc_r <= wacc_r + $signed(prod_r[63:0]);
          pend_r  <= 1'b0;
          state_r <= ST_WSAT;
        end
        ST_WSAT: begin
          // Saturate the leg sum before negating it
          wsum_r  <= sat32(rnd(66'(wacc_r), lqrbc_pkg::GAIN_FRAC));
          force_r <= sat32(-66'(sat32(rnd(66'(lacc_r), lqrbc_pkg::GAIN_FRAC))));
          state_r <= ST_M_TAU;
        end
        ST_M_TAU: state_r <= ST_TAU;
        ST_TAU: begin
          tau_r   <= sat32(-rnd(prod, FB + 1));
          state_r <= ST_LR;
        end
        ST_LR: begin
          left_r  <= sat32(66'(tau_r) - 66'(in_r.yaw_cmd));
          right_r <= sat32(66'(tau_r) + 66'(in_r.yaw_cmd));
          if (ls_r == '0) begin
            state_r <= ST_M_TURN;
          end else begin
            leg_ref_r <= '0;
            state_r   <= ST_FINISH;
          end
        end
        ST_M_TURN: begin
          lrsum_r <= 33'(left_r) + 33'(right_r);
          state_r <= ST_TURN;
        end
        ST_TURN: begin
          t_r     <= prod_r[FB + 31 -: 32];
          state_r <= ST_SA;
        end
        ST_SA: state_r <= ST_SB;
        ST_SB: begin
          sa_r    <= rom_q;
          state_r <= ST_CA;
        end
        ST_CA: begin
          diff_r  <= 33'(rom_q) - 33'(sa_r);
          state_r <= ST_CB;
        end
        ST_CB: begin
          ca_r    <= rom_q;
          state_r <= ST_M_C;
        end
        ST_M_C: begin
          s_r     <= sa_r + 32'(prod >>> 16);
          diff_r  <= 33'(rom_q) - 33'(ca_r);
          state_r <= ST_CMUL;
        end
        ST_CMUL: state_r <= ST_GH;
        ST_GH: begin
          c_r     <= ca_r + 32'(prod >>> 16);
          state_r <= ST_MG;
        end
        ST_MG: begin
          ghs_r   <= rnd(prod, lqrbc_pkg::SIN_FRAC - FB);
          state_r <= ST_NUM;
        end
        ST_NUM: begin
          logic signed [65:0] num_w;
          logic signed [65:0] den_w;
          num_w   = (66'(lrsum_r) <<< lqrbc_pkg::GAIN_FRAC) - ghs_r;
          den_w   = rnd(prod, lqrbc_pkg::SIN_FRAC);
          num_r   <= num_w[DVD_W:0];
          den_r   <= den_w[DVS_W:0];
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          // Zero cosine term: saturate by the numerator's sign
          if (den_r == '0) begin
            leg_ref_r <= num_r[DVD_W] ? 32'sh80000000 : 32'sh7fffffff;
            state_r   <= ST_FINISH;
          end else begin
            state_r <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            leg_ref_r <= sat32(q_signed);
            state_r   <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold until the output register is free, then commit the tick
          if (commit) begin
            out_r.left_torque   <= left_r;
            out_r.right_torque  <= right_r;
            out_r.leg_force     <= force_r;
            out_r.leg_reference <= leg_ref_r;
            out_r.second_gains  <= gain_nxt;
            rv_pos_r            <= posref_r;
            rv_leg_r            <= leg_ref_r;
            rv_pitch_r          <= lp_r;
            rv_speed_r          <= ls_r;
            gain_r              <= gain_nxt;
            tick_r              <= tick_r + 1'b1;
            state_r             <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

// File: src/lqrbc_checker.sv
// Port-level checks of the LQR balance controller, bound to its top level.
// Depends on lqrbc_pkg and lqr_balance_controller_core.
`default_nettype none
module lqrbc_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire lqrbc_pkg::in_item_t  in_item,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire lqrbc_pkg::out_item_t out_item,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire logic [2:0]           cfg_index,
  input wire logic [16:0]          cfg_data
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Taking an item makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an accepted item");

  // A new result appears exactly as the sequencer returns to idle
  a_result_with_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while still busy");

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind lqr_balance_controller_core lqrbc_checker u_lqrbc_checker (.*);
`default_nettype wire

// File: tb/tb_lqr_balance_controller_core.sv
// Self-checking testbench of lqr_balance_controller_core. Drives control ticks
// through valid/ready and checks every result item against a local predictor or a directed expected value.
// Depends on lqrbc_pkg and the controller RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_lqr_balance_controller_core;

  localparam int  SINE_DEPTH   = 1024;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint S32_MAX     = 64'sd2147483647;
  localparam longint S32_MIN     = -64'sd2147483648;
  // indexes outside the register map, writes there must be ignored
  localparam logic [2:0] CFG_UNMAPPED_LO = 3'd5;
  localparam logic [2:0] CFG_UNMAPPED_HI = 3'd7;
  localparam int  RAND_ITEMS   = 1030;
  localparam int  SETTLE_CYCLES = 120;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  lqrbc_pkg::in_item_t  in_item;
  logic                 out_valid;
  logic                 out_ready;
  lqrbc_pkg::out_item_t out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [2:0]           cfg_index;
  logic [16:0]          cfg_data;

  lqr_balance_controller_core #(.SINE_TABLE_DEPTH(SINE_DEPTH)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of registers and controller state
  longint vel_step, pitch_step, switch_tick, radius, period;
  longint lim_speed, lim_pitch, pos_ref;
  longint rv_pos, rv_leg, rv_pitch, rv_speed;
  longint tick_cnt;
  bit     use_second;
  longint sine_tbl [SINE_DEPTH];

  lqrbc_pkg::out_item_t torque_q[$];   // expected result items, oldest first
  int        n_errors;
  int        idle_pct;
  int        stall_pct;

  function automatic longint rnd_sh(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat32(longint x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  function automatic longint slew(longint cur, longint cmd, longint step);
    longint d;
    d = cmd - cur;
    if (d >= step) return cur + step;
    if (d <= -step) return cur - step;
    return cmd;
  endfunction

  // Full-turn Q.30 sine table from a Taylor series on the folded angle
  function automatic void build_sine();
    longint x, x2, term, sum;
    bit neg;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      x = TWO_PI_Q30 * k / SINE_DEPTH;
      neg = 1'b0;
      if (x > PI_Q30) begin
        x = x - PI_Q30;
        neg = 1'b1;
      end
      if (x > HALF_PI_Q30) x = PI_Q30 - x;
      x2 = (x * x) >>> lqrbc_pkg::SIN_FRAC;
      term = x;
      sum = x;
      for (int n = 1; n <= 9; n++) begin
        term = (-((term * x2) >>> lqrbc_pkg::SIN_FRAC)) / longint'((2 * n) * (2 * n + 1));
        sum += term;
      end
      if (sum > (64'sd1 <<< lqrbc_pkg::SIN_FRAC)) sum = 64'sd1 <<< lqrbc_pkg::SIN_FRAC;
      if (sum < 0) sum = 0;
      sine_tbl[k] = neg ? -sum : sum;
    end
  endfunction

  function automatic longint sine_of_turn(logic [31:0] t);
    longint unsigned p;
    longint idx, frac, a, b;
    p = longint'(t) * SINE_DEPTH;
    idx = (p >> 32) % SINE_DEPTH;
    frac = (p >> 16) & 64'hFFFF;
    a = sine_tbl[idx];
    b = sine_tbl[(idx + 1) % SINE_DEPTH];
    return a + (((b - a) * frac) >>> 16);
  endfunction

  function automatic lqrbc_pkg::out_item_t control_tick(lqrbc_pkg::in_item_t it);
    lqrbc_pkg::out_item_t r;
    longint x [lqrbc_pkg::STATE_DIM];
    longint rv [lqrbc_pkg::STATE_DIM];
    longint spd, wsum, lsum, e, tau, left, right, leg_f, leg_ref, s, c, num, den;
    logic [31:0] turn;
    int g;
    g = use_second ? 1 : 0;
    wsum = 0;
    lsum = 0;
    leg_ref = 0;
    lim_speed = slew(lim_speed, longint'(it.speed_cmd), vel_step);
    lim_pitch = slew(lim_pitch, longint'(it.pitch_cmd), pitch_step);
    spd = sat32(rnd_sh((longint'(it.left_wheel_speed) + longint'(it.right_wheel_speed))
                       * radius, lqrbc_pkg::FRAC_BITS + 1));
    pos_ref = sat32(pos_ref + rnd_sh(lim_speed * period, lqrbc_pkg::FRAC_BITS));
    x[0] = it.body_pos;   x[1] = it.leg_pos;  x[2] = it.body_pitch;
    x[3] = spd;           x[4] = it.leg_vel;  x[5] = it.pitch_rate;
    rv[0] = rv_pos; rv[1] = rv_leg; rv[2] = rv_pitch; rv[3] = rv_speed;
    rv[4] = 0;      rv[5] = 0;
    for (int i = 0; i < lqrbc_pkg::STATE_DIM; i++) begin
      e = sat32(x[i] - rv[i]);
      wsum += longint'(lqrbc_pkg::WHEEL_GAIN[g][i]) * e;
      lsum += longint'(lqrbc_pkg::LEG_GAIN[g][i]) * e;
    end
    wsum = sat32(rnd_sh(wsum, lqrbc_pkg::GAIN_FRAC));
    lsum = sat32(rnd_sh(lsum, lqrbc_pkg::GAIN_FRAC));
    tau = sat32(-rnd_sh(wsum * radius, lqrbc_pkg::FRAC_BITS + 1));
    leg_f = sat32(-lsum);
    left = sat32(tau - longint'(it.yaw_cmd));
    right = sat32(tau + longint'(it.yaw_cmd));
    // static leg reference only while the speed reference is at rest
    if (lim_speed == 0) begin
      turn = 32'((lim_pitch * longint'(lqrbc_pkg::INV_2PI_Q32)) >>> lqrbc_pkg::FRAC_BITS);
      s = sine_of_turn(turn);
      c = sine_of_turn(turn + 32'h4000_0000);
      num = (left + right) * (64'sd1 <<< lqrbc_pkg::GAIN_FRAC)
            - rnd_sh(longint'(lqrbc_pkg::GH_Q20) * s,
                     lqrbc_pkg::SIN_FRAC - lqrbc_pkg::FRAC_BITS);
      den = rnd_sh(longint'(lqrbc_pkg::MG_Q20) * c, lqrbc_pkg::SIN_FRAC);
      if (den == 0) leg_ref = (num >= 0) ? S32_MAX : S32_MIN;
      else leg_ref = sat32(num / den);
    end
    rv_pos = pos_ref;
    rv_leg = leg_ref;
    rv_pitch = lim_pitch;
    rv_speed = lim_speed;
    if (tick_cnt == switch_tick) use_second = 1'b1;
    tick_cnt = (tick_cnt + 1) & 64'hFFFF;
    r.left_torque = 32'(left);
    r.right_torque = 32'(right);
    r.leg_force = 32'(leg_f);
    r.leg_reference = 32'(leg_ref);
    r.second_gains = use_second;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] got);
    if (exp_v !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name, exp_v, got);
      n_errors++;
    end
  endfunction

  // Signed value spread evenly over [-span, span]
  function automatic int srand(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Hold the item until accepted, then queue its prediction
  task automatic send_tick(lqrbc_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    torque_q.push_back(control_tick(it));
  endtask

  // Drain outstanding items and let the block settle, then write one register
  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    in_valid <= 1'b0;
    while (torque_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lqrbc_pkg::CFG_VEL_STEP:    vel_step = val;
      lqrbc_pkg::CFG_PITCH_STEP:  pitch_step = val;
      lqrbc_pkg::CFG_GAIN_SWITCH: switch_tick = val[15:0];
      lqrbc_pkg::CFG_WHEEL_RAD:   radius = val;
      lqrbc_pkg::CFG_TICK_PERIOD: period = val;
      default: ;
    endcase
  endtask

  function automatic lqrbc_pkg::in_item_t random_tick();
    lqrbc_pkg::in_item_t it;
    if ($urandom_range(99) < 75) begin
      // plausible tick: small states, speed command often zero for the rest path
      it.body_pos = srand(1 << 18);
      it.leg_pos = srand(1 << 16);
      it.leg_vel = srand(1 << 17);
      it.body_pitch = srand(1 << 16);
      it.pitch_rate = srand(1 << 18);
      it.left_wheel_speed = srand(1 << 22);
      it.right_wheel_speed = srand(1 << 22);
      it.speed_cmd = ($urandom_range(1) == 0) ? 0 : srand(1 << 17);
      it.yaw_cmd = srand(1 << 20);
      it.pitch_cmd = ($urandom_range(3) == 0) ? srand(110000) : srand(1 << 14);
    end else begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom};
    end
    return it;
  endfunction

  function automatic logic [16:0] pick_limit();
    case ($urandom_range(4))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(0, 65536));
      default: return 17'($urandom_range(1, 3000));
    endcase
  endfunction

  // Directed rows: an item, or a register write where is_cfg is set
  typedef struct {
    bit                   is_cfg;
    logic [2:0]           idx;
    logic [16:0]          val;
    lqrbc_pkg::in_item_t  it;
    bit                   has_exp;
    lqrbc_pkg::out_item_t exp_r;
  } dir_row_t;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: take items with random stalls, compare against the oldest expectation
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (torque_q.size() == 0) begin
          $display("%0t: unexpected result item: expected none, actual %h",
                   $realtime, out_item);
          n_errors++;
        end else begin
          lqrbc_pkg::out_item_t w;
          w = torque_q.pop_front();
          compare_field("left_torque", w.left_torque, out_item.left_torque);
          compare_field("right_torque", w.right_torque, out_item.right_torque);
          compare_field("leg_force", w.leg_force, out_item.leg_force);
          compare_field("leg_reference", w.leg_reference, out_item.leg_reference);
          compare_field("second_gains", 32'(w.second_gains), 32'(out_item.second_gains));
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    lqrbc_pkg::in_item_t z;
    int idle_tab[4] = '{0, 46, 0, 25};
    int stall_tab[4] = '{0, 0, 46, 25};

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = lqrbc_pkg::CFG_VEL_STEP;
    cfg_data = '0;
    n_errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    vel_step = 92; pitch_step = 13; switch_tick = 1500; radius = 4260; period = 131;
    lim_speed = 0; lim_pitch = 0; pos_ref = 0;
    rv_pos = 0; rv_leg = 0; rv_pitch = 0; rv_speed = 0;
    tick_cnt = 0; use_second = 1'b0;
    build_sine();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    z = '0;
    row = '{is_cfg: 0, idx: lqrbc_pkg::CFG_VEL_STEP, val: 0, it: z, has_exp: 1, exp_r: '0};
    // quiet tick straight after reset: everything zero
    rows.push_back(row);
    // yaw extremes alone: torques at or near full scale, leg reference stays zero
    row.it.yaw_cmd = 32'sh8000_0000;
    row.exp_r = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 1'b0};
    rows.push_back(row);
    row.it.yaw_cmd = 32'sh7FFF_FFFF;
    row.exp_r = '{32'sh8000_0001, 32'sh7FFF_FFFF, 0, 0, 1'b0};
    rows.push_back(row);
    row.has_exp = 0;
    row.it = {10{32'sh7FFF_FFFF}};
    rows.push_back(row);
    row.it = {10{32'sh8000_0000}};
    rows.push_back(row);
    row.it = z;
    row.it.left_wheel_speed = 32'sh7FFF_FFFF;
    row.it.right_wheel_speed = 32'sh7FFF_FFFF;
    rows.push_back(row);
    // zero step limits hold both references, zero period freezes position
    row.is_cfg = 1; row.idx = lqrbc_pkg::CFG_VEL_STEP; row.val = 0; rows.push_back(row);
    row.idx = lqrbc_pkg::CFG_PITCH_STEP;  row.val = 0;      rows.push_back(row);
    row.idx = lqrbc_pkg::CFG_TICK_PERIOD; row.val = 0;      rows.push_back(row);
    row.idx = lqrbc_pkg::CFG_GAIN_SWITCH; row.val = 17'd12; rows.push_back(row);
    row.idx = CFG_UNMAPPED_LO; row.val = 17'h1FFFF; rows.push_back(row);
    row.is_cfg = 0;
    row.it = z;
    row.it.speed_cmd = 32'sh0100_0000;
    row.it.pitch_cmd = -32'sd50000;
    rows.push_back(row);
    // widest settings: snap to commands, radius and period of 65536
    row.is_cfg = 1;
    row.idx = lqrbc_pkg::CFG_VEL_STEP;    row.val = 17'd65536; rows.push_back(row);
    row.idx = lqrbc_pkg::CFG_PITCH_STEP;  row.val = 17'd65536; rows.push_back(row);
    row.idx = lqrbc_pkg::CFG_TICK_PERIOD; row.val = 17'd65536; rows.push_back(row);
    row.idx = lqrbc_pkg::CFG_WHEEL_RAD;   row.val = 17'd65536; rows.push_back(row);
    row.idx = CFG_UNMAPPED_HI; row.val = 17'd0;     rows.push_back(row);
    row.is_cfg = 0;
    row.it = z;
    row.it.speed_cmd = 32'sd40000;
    rows.push_back(row);
    // at rest near a quarter turn, cosine term at or near zero, and near a half turn
    foreach (idle_tab[k]) begin
      row.it = z;
      row.it.body_pitch = 32'sd1000 * k;
      row.it.pitch_cmd = 32'sd102942 + k;
      rows.push_back(row);
    end
    row.it = z; row.it.pitch_cmd = -32'sd102944; rows.push_back(row);
    row.it = z; row.it.pitch_cmd = 32'sd205887;  rows.push_back(row);
    row.it = z; row.it.pitch_cmd = 32'sh7FFF_FFFF; row.it.yaw_cmd = 32'sd77;
    rows.push_back(row);
    row.it = z; row.it.pitch_cmd = 32'sh8000_0000; rows.push_back(row);
    row.is_cfg = 1; row.idx = lqrbc_pkg::CFG_WHEEL_RAD; row.val = 17'd0; rows.push_back(row);
    row.is_cfg = 0;
    row.it = {10{32'sh1234_5678}};
    rows.push_back(row);

    foreach (rows[r]) begin
      if (rows[r].is_cfg) begin
        write_reg(rows[r].idx, rows[r].val);
      end else begin
        send_tick(rows[r].it);
        // replace the prediction with the value read straight off the behaviour
        if (rows[r].has_exp) torque_q[torque_q.size() - 1] = rows[r].exp_r;
      end
    end

    // Random part: four phases of input idling and output stalls, fresh register settings before each
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(lqrbc_pkg::CFG_VEL_STEP, pick_limit());
      write_reg(lqrbc_pkg::CFG_PITCH_STEP, pick_limit());
      write_reg(lqrbc_pkg::CFG_GAIN_SWITCH,
                (ph == 3) ? 17'h0FFFF : 17'(tick_cnt + $urandom_range(5, 200)));
      write_reg(lqrbc_pkg::CFG_WHEEL_RAD,
                (ph == 1) ? 17'd65536 : 17'($urandom_range(0, 65536)));
      write_reg(lqrbc_pkg::CFG_TICK_PERIOD,
                (ph == 2) ? 17'd0 : 17'($urandom_range(1, 65536)));
      idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      for (int n = 0; n < RAND_ITEMS / 4; n++) send_tick(random_tick());
    end
    in_valid <= 1'b0;

    while (torque_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
